// ===== sv/ist_pkg.sv =====
// Package for the integer set table: sizes, codes, state encoding and the
// memory request bundle. Depends on nothing; every other file imports it.
package ist_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam int OPCODE_W = 2;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   typedef enum logic [OPCODE_W-1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_CLEAR  = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK   = 2'd0,
      STAT_MISS = 2'd1,
      STAT_FULL = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_FINISH
   } state_type;

   // One write port and one read port per cycle.
   typedef struct packed {
      logic               wr_en;
      logic [IDX_W-1:0]   wr_addr;
      logic [VALUE_W-1:0] wr_data;
      logic               rd_en;
      logic [IDX_W-1:0]   rd_addr;
   } mem_req_type;

endpackage

// ===== sv/ist_mem.sv =====
// Element store of the integer set table: a simple dual-port synchronous RAM
// with registered read data. Depends on ist_pkg.
module ist_mem
   import ist_pkg::*;
(
   input  logic               clock,
   input  mem_req_type        mem_req,
   output logic [VALUE_W-1:0] rd_data
);

   logic [VALUE_W-1:0] store_mem [CAPACITY];
   logic [VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         store_mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= store_mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/integer_set_table_top.sv =====
// Top level of the integer set table: control sequencer, scan and shift
// pipeline, count register and result register. Depends on ist_pkg, ist_mem.
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_valid/req_stall  req_opcode, req_value
//   rsp_      out        rsp_valid/rsp_stall  rsp_status, rsp_count
//
// Insert and lookup scan until they find the value or pass the last entry;
// remove scans to the value, then shifts the entries behind it down, so its
// run is much the same wherever it finds the value; clear does no scan.
// The store's single read port feeds one entry per cycle to the comparator.
// Reset clears the element count, the sequencer state and the valid flags; the store itself is
// not cleared, since only entries below the count are ever read.
// A stalled result waits in the output register while the next transfer on
// the request side is taken; the sequencer holds its result only when that
// register is full and stalled.
module integer_set_table_top
   import ist_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [OPCODE_W-1:0]        req_opcode,
   input  logic signed [VALUE_W-1:0]  req_value,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [COUNT_W-1:0]         rsp_count
);

   state_type          state_ff, state_in;
   opcode_type         op_ff, op_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   status_type         res_status_ff, res_status_in;

   // Scan pipeline: an address stage that issues reads and a compare stage
   // that sees the read data in the following cycle.
   logic [IDX_W-1:0]   scan_addr_ff, scan_addr_in;
   logic               scan_last_ff, scan_last_in;
   logic               cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0]   cmp_idx_ff, cmp_idx_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   mem_req_type        mem_req;
   logic [VALUE_W-1:0] rd_data;

   logic               req_accept;
   logic               out_free;
   logic               issue;
   logic               hit;
   logic               at_last;
   logic               miss_done;
   logic [IDX_W-1:0]   last_idx;

   ist_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // The block takes a new request only between operations.
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // The last live entry; only meaningful while the count is nonzero.
   assign last_idx  = IDX_W'(count_ff - CNT_W'(1));
   assign issue     = ((state_ff == ST_SCAN) || (state_ff == ST_SHIFT)) &&
                      (count_ff != '0) && !scan_last_ff;
   assign hit       = cmp_valid_ff && (rd_data == value_ff);
   assign at_last   = cmp_valid_ff && (cmp_idx_ff == last_idx);
   // An empty set, or a scan whose final compare found nothing.
   assign miss_done = (count_ff == '0) || (at_last && !hit);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = (opcode_type'(req_opcode) == OP_CLEAR) ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (hit) begin
               // Removing anything but the last entry needs the gap closed.
               state_in = ((op_ff == OP_REMOVE) && !at_last) ? ST_SHIFT : ST_FINISH;
            end else if (miss_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_SHIFT: begin
            if (at_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and memory control.
   always_comb begin
      op_in         = op_ff;
      value_in      = value_ff;
      count_in      = count_ff;
      res_status_in = res_status_ff;
      scan_addr_in  = scan_addr_ff;
      scan_last_in  = scan_last_ff;
      cmp_valid_in  = issue;
      cmp_idx_in    = scan_addr_ff;

      mem_req         = '0;
      mem_req.rd_en   = issue;
      mem_req.rd_addr = scan_addr_ff;

      if (issue) begin
         scan_addr_in = scan_addr_ff + IDX_W'(1);
         scan_last_in = (scan_addr_ff == last_idx);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               op_in        = opcode_type'(req_opcode);
               value_in     = req_value;
               scan_addr_in = '0;
               scan_last_in = 1'b0;
               if (opcode_type'(req_opcode) == OP_CLEAR) begin
                  count_in      = '0;
                  res_status_in = STAT_OK;
               end
            end
         end
         ST_SCAN: begin
            if (hit) begin
               case (op_ff)
                  OP_INSERT: res_status_in = STAT_MISS;
                  OP_REMOVE: begin
                     res_status_in = STAT_OK;
                     // The last entry simply drops out of the count.
                     if (at_last) begin
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  default:   res_status_in = STAT_OK;
               endcase
            end else if (miss_done) begin
               if (op_ff == OP_INSERT) begin
                  if (count_ff >= CNT_W'(CAPACITY)) begin
                     res_status_in = STAT_FULL;
                  end else begin
                     res_status_in   = STAT_OK;
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_addr = IDX_W'(count_ff);
                     mem_req.wr_data = value_ff;
                     count_in        = count_ff + CNT_W'(1);
                  end
               end else begin
                  res_status_in = STAT_MISS;
               end
            end
         end
         ST_SHIFT: begin
            // Each entry read moves down by one; the write address trails the read by two.
            if (cmp_valid_ff) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = cmp_idx_ff - IDX_W'(1);
               mem_req.wr_data = rd_data;
               if (at_last) begin
                  count_in = count_ff - CNT_W'(1);
               end
            end
         end
         ST_FINISH: begin
         end
         default: begin
         end
      endcase
   end

   // Result register: loaded as the sequencer finishes, drained by the consumer.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      if ((state_ff == ST_FINISH) && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_count_in  = COUNT_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         scan_last_ff <= 1'b0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         scan_last_ff <= scan_last_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      value_ff      <= value_in;
      res_status_ff <= res_status_in;
      scan_addr_ff  <= scan_addr_in;
      cmp_idx_ff    <= cmp_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_count  = rsp_count_ff;

   // The count never passes the capacity of the store.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("element count exceeds capacity");

   // During a shift the write always trails the read, so they never collide.
   a_shift_no_collide: assert property (@(posedge clock) disable iff (reset)
      (mem_req.wr_en && mem_req.rd_en) |-> (mem_req.wr_addr != mem_req.rd_addr))
      else $error("read and write of the same entry in one cycle");

   // An accepted clear leaves an empty set.
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (opcode_type'(req_opcode) == OP_CLEAR)) |=> (count_ff == '0))
      else $error("clear did not empty the set");

   // The final move of a shift removes exactly one element.
   a_shift_decrement: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SHIFT) && at_last) |=>
         (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("remove did not decrement the count");

   // Leaving the finishing state loads a result and returns the sequencer to idle.
   a_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FINISH) && out_free) |=> (rsp_valid_ff && (state_ff == ST_IDLE)))
      else $error("finished operation produced no result");

endmodule

// ===== dv/testbench.sv =====
// Self-checking bench for integer_set_table_top: directed and random set operations,
// with each result checked against a predictor that keeps its own copy of the set.
// Depends on ist_pkg and the RTL under sv/.
`timescale 1ns / 1ps

module testbench
   import ist_pkg::*;
();

   // Total number of operations to aim for, the directed part included.
   localparam int NUM_OPS   = 1400;
   // Pool of candidate values. It is larger than the table so that fill runs can
   // overflow the table, and reused values cause hits on remove and lookup.
   localparam int POOL_SIZE = CAPACITY + 24;
   // Operations in this range get no random idle cycles on either side.
   localparam int QUIET_LO  = 700;
   localparam int QUIET_HI  = 900;
   // Idle probability, in percent, for each side outside the quiet window.
   localparam int IDLE_PCT  = 27;

   typedef struct {
      opcode_type         opcode;
      logic [VALUE_W-1:0] value;
      bit                 steady;      // no random idle cycle before this transfer
      bit                 drain_first; // hold off until every result is back
   } set_request_type;

   typedef struct {
      status_type         status;
      logic [COUNT_W-1:0] count;
   } set_outcome_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [OPCODE_W-1:0]        req_opcode = OP_INSERT;
   logic signed [VALUE_W-1:0]  req_value = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [STATUS_W-1:0]        rsp_status;
   logic [COUNT_W-1:0]         rsp_count;

   // Requests waiting to be driven, and outcomes waiting for their result.
   set_request_type pending_ops[$];
   set_outcome_type expected_outcomes[$];

   // The predictor's own copy of the set: live members sit below member_total.
   logic [VALUE_W-1:0] members [CAPACITY];
   int                 member_total = 0;

   logic [VALUE_W-1:0] value_pool [POOL_SIZE];
   int                 queued_total = 0;
   int                 results_seen = 0;
   int                 error_count  = 0;
   logic               req_taken    = 1'b0;

   integer_set_table_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_status (rsp_status),
      .rsp_count  (rsp_count)
   );

   // 4 ns clock period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Applies one operation to the predicted set and returns the result the block
   // should give. A duplicate insert is detected before the table is checked for
   // room, so a duplicate into a full table reports "already present".
   function automatic set_outcome_type apply_set_op(input opcode_type op,
                                                    input logic [VALUE_W-1:0] v);
      set_outcome_type res;
      int              hit;
      int              i;
      hit = -1;
      for (i = 0; i < member_total; i++) begin
         if (hit < 0 && members[i] == v) hit = i;
      end
      res.status = STAT_OK;
      case (op)
         OP_INSERT: begin
            if (hit >= 0) begin
               res.status = STAT_MISS;
            end else if (member_total >= CAPACITY) begin
               res.status = STAT_FULL;
            end else begin
               members[member_total] = v;
               member_total++;
            end
         end
         OP_REMOVE: begin
            if (hit < 0) begin
               res.status = STAT_MISS;
            end else begin
               // Close the gap so that the remaining members keep their order.
               for (i = hit; i + 1 < member_total; i++) members[i] = members[i + 1];
               member_total--;
            end
         end
         OP_LOOKUP: begin
            res.status = (hit >= 0) ? STAT_OK : STAT_MISS;
         end
         default: begin
            // Clear only drops the count; old entries stay but are no longer live.
            member_total = 0;
         end
      endcase
      res.count = COUNT_W'(member_total);
      return res;
   endfunction

   // Mostly values from the pool, so that hits are common; otherwise any 32-bit value.
   function automatic logic [VALUE_W-1:0] pick_value();
      if ($urandom_range(0, 99) < 80) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
      return $urandom;
   endfunction

   // Queues one operation. The position in the stream decides whether it falls in
   // the quiet window and whether the sender first waits for all results.
   task automatic queue_op(input opcode_type op, input logic [VALUE_W-1:0] v);
      set_request_type item;
      item.opcode      = op;
      item.value       = v;
      item.steady      = (queued_total >= QUIET_LO && queued_total < QUIET_HI);
      item.drain_first = (queued_total == 30) || (queued_total % 400 == 399);
      pending_ops.push_back(item);
      queued_total++;
   endtask

   // Request driver. Inputs change on the falling edge. A transfer that is still
   // stalled keeps its payload; once it has gone, the next one is presented right
   // away or held back at random. An operation marked drain_first waits until
   // the block has returned every outstanding result.
   always @(negedge clock) begin : drive_requests
      set_request_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_ops.size() != 0
             && !(pending_ops[0].drain_first && expected_outcomes.size() != 0)
             && (pending_ops[0].steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
            item = pending_ops.pop_front();
            req_valid  <= 1'b1;
            req_opcode <= item.opcode;
            req_value  <= item.value;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result side stalls at random, except during the quiet window.
   always @(negedge clock) begin
      if (results_seen >= QUIET_LO && results_seen < QUIET_HI) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < IDLE_PCT);
      end
   end

   // Monitor and predictor, both on the rising edge. A result transfer is checked
   // before a request transfer at the same edge is predicted, since the result
   // always belongs to an older request.
   always @(posedge clock) begin : check_results
      set_outcome_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_outcomes.size() == 0) begin
               error_count++;
               $display("%0t: result with nothing expected, actual status %0d count %0d",
                        $time, rsp_status, rsp_count);
            end else begin
               want = expected_outcomes.pop_front();
               if (rsp_status !== want.status) begin
                  error_count++;
                  $display("%0t: status mismatch, expected %0d, actual %0d",
                           $time, want.status, rsp_status);
               end
               if (rsp_count !== want.count) begin
                  error_count++;
                  $display("%0t: count mismatch, expected %0d, actual %0d",
                           $time, want.count, rsp_count);
               end
            end
         end
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            expected_outcomes.push_back(apply_set_op(opcode_type'(req_opcode), req_value));
         end
      end
   end

   // Stimulus and end of test.
   initial begin : stimulus
      int base;
      int run;
      int k;
      int roll;

      value_pool[0] = 32'h8000_0000;
      value_pool[1] = 32'h7FFF_FFFF;
      value_pool[2] = 32'h0000_0000;
      value_pool[3] = 32'hFFFF_FFFF;
      for (k = 4; k < POOL_SIZE; k++) value_pool[k] = $urandom;

      // Directed part: operations on the empty set, the value extremes, a
      // duplicate insert, removal at the head and at the tail (the tail needs no
      // shift), and stale entries after a clear that must not count as members.
      queue_op(OP_LOOKUP, 32'h0000_0000);
      queue_op(OP_REMOVE, 32'h0000_0000);
      queue_op(OP_INSERT, 32'h8000_0000);
      queue_op(OP_INSERT, 32'h7FFF_FFFF);
      queue_op(OP_INSERT, 32'h0000_0000);
      queue_op(OP_INSERT, 32'hFFFF_FFFF);
      queue_op(OP_INSERT, 32'h7FFF_FFFF);
      queue_op(OP_LOOKUP, 32'hFFFF_FFFF);
      queue_op(OP_LOOKUP, 32'h0000_0001);
      queue_op(OP_REMOVE, 32'h8000_0000);
      queue_op(OP_LOOKUP, 32'h8000_0000);
      queue_op(OP_REMOVE, 32'hFFFF_FFFF);
      queue_op(OP_LOOKUP, 32'h7FFF_FFFF);
      queue_op(OP_INSERT, 32'h5555_AAAA);
      queue_op(OP_CLEAR,  32'hA5A5_5A5A);
      queue_op(OP_LOOKUP, 32'h0000_0000);
      queue_op(OP_REMOVE, 32'h7FFF_FFFF);
      queue_op(OP_CLEAR,  32'h0000_0000);
      queue_op(OP_INSERT, 32'h0000_0000);
      queue_op(OP_REMOVE, 32'h0000_0000);

      // Random part. Fill runs empty the set, insert a run of pool values that can
      // reach or pass capacity, retry values from that run, then remove some. Mixed
      // runs use random operations, mostly on pool values.
      while (queued_total < NUM_OPS) begin
         if ($urandom_range(0, 2) == 0) begin
            queue_op(OP_CLEAR, $urandom);
            base = $urandom_range(0, POOL_SIZE - 1);
            run  = $urandom_range(CAPACITY - 4, CAPACITY + 8);
            for (k = 0; k < run; k++) begin
               queue_op(OP_INSERT, value_pool[(base + k) % POOL_SIZE]);
               if ($urandom_range(0, 9) == 0) queue_op(OP_LOOKUP, pick_value());
            end
            repeat ($urandom_range(2, 6)) begin
               queue_op(OP_INSERT, value_pool[(base + $urandom_range(0, run - 1)) % POOL_SIZE]);
            end
            repeat ($urandom_range(3, 12)) queue_op(OP_REMOVE, pick_value());
         end else begin
            repeat ($urandom_range(30, 60)) begin
               roll = $urandom_range(0, 99);
               if (roll < 40) begin
                  queue_op(OP_INSERT, pick_value());
               end else if (roll < 65) begin
                  queue_op(OP_REMOVE, pick_value());
               end else if (roll < 97) begin
                  queue_op(OP_LOOKUP, pick_value());
               end else begin
                  queue_op(OP_CLEAR, $urandom);
               end
            end
         end
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait until every operation has been transferred and answered, then let the
      // clock run on so that any stray result from the block would show.
      while (!(pending_ops.size() == 0 && !req_valid && expected_outcomes.size() == 0)) begin
         @(posedge clock);
      end
      repeat (CAPACITY + 8) @(posedge clock);

      if (error_count == 0) begin
         $display("integer_set_table_top verification clean");
      end else begin
         $display("integer_set_table_top verification failed");
      end
      $finish;
   end

   // Watchdog: fails the test if it runs far beyond the slowest legal run.
   initial begin
      #4_000_000;
      $display("integer_set_table_top verification failed");
      $finish;
   end

endmodule

// ===== files.f =====
sv/ist_pkg.sv
sv/ist_mem.sv
sv/integer_set_table_top.sv
dv/testbench.sv
